[rtl/chw_pkg.sv]
package chw_pkg;

   // sample format
   localparam int SAMPLE_BITS = 24;
   localparam int FRAC_BITS   = SAMPLE_BITS - 1;

   // register widths
   localparam int DRIVE_W  = 17;
   localparam int THRESH_W = 23;
   localparam int GAIN_W   = 16;
   localparam int BLEN_W   = 13;
   localparam int POS_W    = 12;
   localparam int RAMP_W   = 32;

   localparam int MAX_BLOCK = 4096;

   // lane datapath widths
   localparam int ACC_W    = 25;   // sq, cube, drive product
   localparam int VAL_W    = 26;   // stage values and the blended sum
   localparam int MUL_A_W  = 27;
   localparam int MUL_B_W  = 24;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;

   // floor(v/3) = (v * (2^25+1)/3) >> 25, exact for v < 2^25
   localparam int RECIP_SHIFT = 25;
   localparam logic [MUL_B_W-1:0] RECIP_THIRD = 24'd11184811;

   // lane sequence steps
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_SQ_A   = 4'd0;
   localparam logic [STEP_W-1:0] STEP_CU_A   = 4'd1;
   localparam logic [STEP_W-1:0] STEP_TM_A   = 4'd2;
   localparam logic [STEP_W-1:0] STEP_TH_A   = 4'd3;
   localparam logic [STEP_W-1:0] STEP_SQ_B   = 4'd4;
   localparam logic [STEP_W-1:0] STEP_CU_B   = 4'd5;
   localparam logic [STEP_W-1:0] STEP_TM_B   = 4'd6;
   localparam logic [STEP_W-1:0] STEP_TH_B   = 4'd7;
   localparam logic [STEP_W-1:0] STEP_SUM    = 4'd8;
   localparam logic [STEP_W-1:0] STEP_GAIN   = 4'd9;
   localparam logic [STEP_W-1:0] STEP_LAST   = STEP_GAIN;

   // configuration port
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 23;
   localparam logic [CSR_INDEX_W-1:0] CSR_DRIVE_FIRST    = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DRIVE_SECOND   = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLIP_THRESHOLD = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTPUT_GAIN    = 8'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_LENGTH   = 8'd4;

   localparam logic [DRIVE_W-1:0]  DRIVE_RESET  = 17'd45875;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 23'd4194304;
   localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd32768;
   localparam logic [BLEN_W-1:0]   BLEN_RESET   = 13'd512;

   typedef struct packed {
      logic              load;
      logic              run;
      logic [STEP_W-1:0] step;
   } chw_lane_ctl_type;

   typedef struct packed {
      logic [DRIVE_W-1:0]  drive_first;
      logic [DRIVE_W-1:0]  drive_second;
      logic [THRESH_W-1:0] clip_threshold;
   } chw_shape_cfg_type;

   typedef struct packed {
      logic              start;
      logic              neg;
      logic [GAIN_W-1:0] mag;
      logic [BLEN_W-1:0] len;
   } chw_div_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } chw_div_stat_type;

endpackage

[rtl/chw_lane.sv]
// One channel: two cubic soft-clip stages, hard-clip blend, gain and saturation.
// One shared multiplier, one step per cycle.
module chw_lane
   import chw_pkg::*;
(
   input  logic                          clock,
   input  chw_lane_ctl_type              ctl,
   input  chw_shape_cfg_type             cfg,
   input  logic [GAIN_W-1:0]             gain,
   input  logic signed [SAMPLE_BITS-1:0] sample_in,
   output logic signed [SAMPLE_BITS-1:0] sample_out
);

   localparam logic [PROD_W-1:0] HALF_F   = PROD_W'(1) << (FRAC_BITS - 1);
   localparam logic [PROD_W-1:0] HALF_Q16 = PROD_W'(32768);
   localparam logic [PROD_W-1:0] SAT_POS  = (PROD_W'(1) << FRAC_BITS) - PROD_W'(1);
   localparam logic [PROD_W-1:0] SAT_NEG  = PROD_W'(1) << FRAC_BITS;
   localparam logic signed [VAL_W:0] ONE_W = (VAL_W+1)'(1) <<< FRAC_BITS;
   localparam logic signed [SAMPLE_BITS-1:0] OUT_MAX = SAMPLE_BITS'(SAT_POS);
   localparam logic signed [SAMPLE_BITS-1:0] OUT_MIN = SAMPLE_BITS'(SAT_NEG);

   logic signed [VAL_W-1:0]       v_ff, v_in;
   logic [ACC_W-1:0]              acc_ff, acc_in;
   logic signed [SAMPLE_BITS-1:0] hard_ff, hard_in;
   logic signed [SAMPLE_BITS-1:0] out_ff, out_in;

   logic [VAL_W-1:0]              v_mag_full;
   logic [ACC_W-1:0]              v_abs;
   logic [SAMPLE_BITS-1:0]        m;
   logic [MUL_A_W-1:0]            mul_a;
   logic [MUL_B_W-1:0]            mul_b;
   logic [PROD_W-1:0]             prod;
   logic [PROD_W-1:0]             rnd;
   logic [SAMPLE_BITS-1:0]        third;
   logic signed [VAL_W:0]         y_wide;
   logic [DRIVE_W-1:0]            drive_sel;
   logic signed [SAMPLE_BITS-1:0] th_s;

   // hard clip of the incoming sample
   always_comb begin
      th_s = signed'({1'b0, cfg.clip_threshold});
      if (sample_in >= th_s) begin
         hard_in = th_s;
      end else if (sample_in <= -th_s) begin
         hard_in = -th_s;
      end else begin
         hard_in = sample_in;
      end
   end

   assign v_mag_full = v_ff[VAL_W-1] ? VAL_W'(-v_ff) : VAL_W'(v_ff);
   assign v_abs      = v_mag_full[ACC_W-1:0];
   assign m          = v_mag_full[SAMPLE_BITS-1:0];
   assign drive_sel  = (ctl.step == STEP_TM_A) ? cfg.drive_first : cfg.drive_second;
   assign prod       = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      acc_in = acc_ff;
      v_in   = v_ff;
      out_in = out_ff;
      rnd    = '0;
      third  = '0;
      y_wide = '0;
      unique case (ctl.step) inside
         STEP_SQ_A, STEP_SQ_B: begin
            mul_a  = MUL_A_W'(m);
            mul_b  = m;
            acc_in = ACC_W'((prod + HALF_F) >> FRAC_BITS);
         end
         STEP_CU_A, STEP_CU_B: begin
            mul_a  = MUL_A_W'(acc_ff);
            mul_b  = m;
            acc_in = ACC_W'((prod + HALF_F) >> FRAC_BITS);
         end
         STEP_TM_A, STEP_TM_B: begin
            mul_a  = MUL_A_W'(acc_ff);
            mul_b  = MUL_B_W'(drive_sel);
            acc_in = ACC_W'((prod + HALF_Q16) >> 16);
         end
         STEP_TH_A, STEP_TH_B: begin
            // rounded divide by three, pull toward zero, clamp to +/-1.0 after stage A
            mul_a = MUL_A_W'(acc_ff + ACC_W'(1));
            mul_b = RECIP_THIRD;
            third = SAMPLE_BITS'(prod >> RECIP_SHIFT);
            if (v_ff[VAL_W-1]) begin
               y_wide = (VAL_W+1)'(v_ff) + signed'((VAL_W+1)'(third));
            end else begin
               y_wide = (VAL_W+1)'(v_ff) - signed'((VAL_W+1)'(third));
            end
            if (ctl.step == STEP_TH_A) begin
               if (y_wide > ONE_W) begin
                  y_wide = ONE_W;
               end else if (y_wide < -ONE_W) begin
                  y_wide = -ONE_W;
               end
            end
            v_in = VAL_W'(y_wide);
         end
         STEP_SUM: begin
            v_in = v_ff + VAL_W'(hard_ff);
         end
         STEP_GAIN: begin
            mul_a = MUL_A_W'(v_abs);
            mul_b = MUL_B_W'(gain);
            rnd   = (prod + HALF_Q16) >> 16;
            if (v_ff[VAL_W-1]) begin
               out_in = (rnd > SAT_NEG) ? OUT_MIN : SAMPLE_BITS'(-rnd[SAMPLE_BITS-1:0]);
            end else begin
               out_in = (rnd > SAT_POS) ? OUT_MAX : signed'(rnd[SAMPLE_BITS-1:0]);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         v_ff    <= VAL_W'(sample_in);
         hard_ff <= hard_in;
      end else if (ctl.run) begin
         v_ff   <= v_in;
         acc_ff <= acc_in;
         out_ff <= out_in;
      end
   end

   assign sample_out = out_ff;

endmodule

[rtl/chw_step_div.sv]
// Ramp step: (mag * 65536) / len, truncated, sign applied after. One quotient bit per cycle.
module chw_step_div
   import chw_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  chw_div_req_type   req,
   output chw_div_stat_type  stat,
   output logic [RAMP_W-1:0] step
);

   localparam int CNT_W = $clog2(RAMP_W);

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [BLEN_W-1:0] rem_ff, rem_in;
   logic [RAMP_W-1:0] num_ff;
   logic [BLEN_W-1:0] len_ff;
   logic              neg_ff;
   logic [BLEN_W:0]   trial;
   logic              ge;

   assign trial  = {rem_ff, num_ff[RAMP_W-1]};
   assign ge     = trial >= {1'b0, len_ff};
   assign rem_in = ge ? BLEN_W'(trial - {1'b0, len_ff}) : trial[BLEN_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(RAMP_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff <= '0;
         num_ff <= {req.mag, 16'h0000};
         len_ff <= req.len;
         neg_ff <= req.neg;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         num_ff <= {num_ff[RAMP_W-2:0], ge};
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign step      = neg_ff ? RAMP_W'(-num_ff) : num_ff;

endmodule

[rtl/cubic_hardclip_waveshaper_gain_ramp.sv]
// Stereo cubic soft-clip waveshaper with hard-clip blend and output gain ramp.
// req_ channel: one stereo frame per transfer (left in the low 24 bits).
// rsp_ channel: one processed stereo frame per accepted frame, same packing.
// csr_ channel: register writes (index, data), always ready; write only while
//   the block is idle. Unknown indexes are dropped.
// Sequencing: a frame runs the 10 steps of the per-lane sequence around one
//   shared multiplier per channel, then loads the output register. A frame
//   that opens a gain ramp also waits for the bit-serial divider that forms
//   the ramp step. The block takes no new frame until the result of the
//   last one has loaded into the output register.
// Both channels run in parallel lanes; the output register merges them.
// Reset: registers return to their defaults, gain state to 0.5 with no ramp,
//   block position to zero, no frame in flight, rsp_tvalid low.
// Stall: a finished frame waits in the output register while the next frame
//   is taken and processed; it is held there until rsp_tready, and only then
//   does the following result load.
module cubic_hardclip_waveshaper_gain_ramp
   import chw_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [47:0]            req_tdata,   // [23:0] left_in, [47:24] right_in
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [47:0]            rsp_tdata,   // [23:0] left_out, [47:24] right_out
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   // configuration registers
   logic [DRIVE_W-1:0]  drive_first_ff;
   logic [DRIVE_W-1:0]  drive_second_ff;
   logic [THRESH_W-1:0] clip_threshold_ff;
   logic [GAIN_W-1:0]   output_gain_ff;
   logic [BLEN_W-1:0]   block_length_ff;

   // gain ramp state
   logic [GAIN_W-1:0]   prev_gain_ff;
   logic [RAMP_W-1:0]   ramp_gain_ff;
   logic [RAMP_W-1:0]   ramp_step_ff;
   logic [POS_W-1:0]    frame_pos_ff, frame_pos_in;
   logic                ramping_ff;
   logic [GAIN_W-1:0]   gain_ff, gain_in;

   // sequencing
   logic                busy_ff;
   logic                run_ff;
   logic [STEP_W-1:0]   step_ff;
   logic                rsp_valid_ff;
   logic [47:0]         rsp_data_ff;

   logic                accept;
   logic                block_start;
   logic                ramp_start;
   logic                finish;
   logic [BLEN_W-1:0]   len_eff;
   logic [BLEN_W-1:0]   pos_next;
   logic [RAMP_W-1:0]   div_step;

   chw_lane_ctl_type    lane_ctl;
   chw_shape_cfg_type   shape_cfg;
   chw_div_req_type     div_req;
   chw_div_stat_type    div_stat;

   logic signed [SAMPLE_BITS-1:0] left_out, right_out;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !busy_ff;
   assign csr_ready  = 1'b1;

   // block length clamped to [1, MAX_BLOCK]
   always_comb begin
      if (block_length_ff == '0) begin
         len_eff = BLEN_W'(1);
      end else if (block_length_ff > BLEN_W'(MAX_BLOCK)) begin
         len_eff = BLEN_W'(MAX_BLOCK);
      end else begin
         len_eff = block_length_ff;
      end
   end

   assign block_start  = frame_pos_ff == '0;
   assign ramp_start   = block_start && (output_gain_ff != prev_gain_ff);
   assign pos_next     = BLEN_W'(frame_pos_ff) + BLEN_W'(1);
   assign frame_pos_in = (pos_next >= len_eff) ? '0 : pos_next[POS_W-1:0];
   // a ramp's first frame still plays at the old gain
   assign gain_in      = (block_start || !ramping_ff) ? prev_gain_ff
                                                      : ramp_gain_ff[RAMP_W-1 -: GAIN_W];

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         drive_first_ff    <= DRIVE_RESET;
         drive_second_ff   <= DRIVE_RESET;
         clip_threshold_ff <= THRESH_RESET;
         output_gain_ff    <= GAIN_RESET;
         block_length_ff   <= BLEN_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DRIVE_FIRST:    drive_first_ff    <= csr_data[DRIVE_W-1:0];
            CSR_DRIVE_SECOND:   drive_second_ff   <= csr_data[DRIVE_W-1:0];
            CSR_CLIP_THRESHOLD: clip_threshold_ff <= csr_data[THRESH_W-1:0];
            CSR_OUTPUT_GAIN:    output_gain_ff    <= csr_data[GAIN_W-1:0];
            CSR_BLOCK_LENGTH:   block_length_ff   <= csr_data[BLEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // gain ramp bookkeeping; the step for a new ramp lands when the divider finishes
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_gain_ff <= GAIN_RESET;
         ramp_gain_ff <= '0;
         ramp_step_ff <= '0;
         frame_pos_ff <= '0;
         ramping_ff   <= 1'b0;
      end else if (accept) begin
         frame_pos_ff <= frame_pos_in;
         if (block_start) begin
            if (ramp_start) begin
               ramping_ff   <= 1'b1;
               ramp_gain_ff <= {prev_gain_ff, 16'h0000};
               prev_gain_ff <= output_gain_ff;
            end else begin
               ramping_ff <= 1'b0;
            end
         end else if (ramping_ff) begin
            ramp_gain_ff <= ramp_gain_ff + ramp_step_ff;
         end
      end else if (div_stat.done) begin
         ramp_step_ff <= div_step;
         ramp_gain_ff <= ramp_gain_ff + div_step;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         gain_ff <= gain_in;
      end
   end

   // frame sequencer and output register
   assign finish = busy_ff && !run_ff && !div_stat.busy && (!rsp_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         run_ff       <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            busy_ff <= 1'b1;
            run_ff  <= 1'b1;
            step_ff <= STEP_SQ_A;
         end else if (run_ff) begin
            step_ff <= step_ff + STEP_W'(1);
            if (step_ff == STEP_LAST) begin
               run_ff <= 1'b0;
            end
         end else if (finish) begin
            busy_ff <= 1'b0;
         end

         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // merge: both lanes land in one output transfer
   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_data_ff <= {right_out, left_out};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign lane_ctl.load = accept;
   assign lane_ctl.run  = run_ff;
   assign lane_ctl.step = step_ff;

   assign shape_cfg.drive_first    = drive_first_ff;
   assign shape_cfg.drive_second   = drive_second_ff;
   assign shape_cfg.clip_threshold = clip_threshold_ff;

   assign div_req.start = accept && ramp_start;
   assign div_req.neg   = output_gain_ff < prev_gain_ff;
   assign div_req.mag   = (output_gain_ff < prev_gain_ff) ? prev_gain_ff - output_gain_ff
                                                          : output_gain_ff - prev_gain_ff;
   assign div_req.len   = len_eff;

   chw_lane u_lane_left (
      .clock      (clock),
      .ctl        (lane_ctl),
      .cfg        (shape_cfg),
      .gain       (gain_ff),
      .sample_in  (signed'(req_tdata[23:0])),
      .sample_out (left_out)
   );

   chw_lane u_lane_right (
      .clock      (clock),
      .ctl        (lane_ctl),
      .cfg        (shape_cfg),
      .gain       (gain_ff),
      .sample_in  (signed'(req_tdata[47:24])),
      .sample_out (right_out)
   );

   chw_step_div u_step_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .stat  (div_stat),
      .step  (div_step)
   );

   // a taken frame starts the lane sequence at its first step
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff && run_ff && step_ff == STEP_SQ_A)
      else $error("frame transfer did not start the lane sequence");

   // a new ramp always engages the divider
   a_ramp_divides: assert property (@(posedge clock) disable iff (reset)
      accept && ramp_start |=> div_stat.busy && ramping_ff)
      else $error("ramp start without step division");

   // the divider only completes for a frame still in flight
   a_div_in_frame: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> busy_ff && !run_ff)
      else $error("ramp step arrived outside a frame");

   // lanes never run without a frame held
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> busy_ff && !rsp_valid_ff || run_ff && busy_ff)
      else $error("lane sequence running with no frame");

   // a result loads only after the sequence and the divider both finished
   a_finish_order: assert property (@(posedge clock) disable iff (reset)
      finish |-> $past(!run_ff || step_ff == STEP_LAST) && !div_stat.busy)
      else $error("result loaded before lanes finished");

endmodule

[bench/cubic_hardclip_waveshaper_gain_ramp_tb.sv]
module cubic_hardclip_waveshaper_gain_ramp_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import chw_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;  // cycles without any transfer
   localparam int SETTLE_CYCLES  = 40;    // settle time after a drain, longer than a ramp frame
   localparam int RANDOM_FRAMES  = 1950;

   localparam logic [SAMPLE_BITS-1:0] S_MAX = 24'h7FFFFF;
   localparam logic [SAMPLE_BITS-1:0] S_MIN = 24'h800000;
   localparam logic [SAMPLE_BITS-1:0] S_ONE = 24'h000001;
   localparam logic [SAMPLE_BITS-1:0] S_NEG_ONE = 24'hFFFFFF;
   localparam logic [SAMPLE_BITS-1:0] S_HALF = 24'h400000;
   localparam logic [SAMPLE_BITS-1:0] S_NEG_HALF = 24'hC00000;
   localparam longint SAMPLE_UNITY = longint'(1) << FRAC_BITS;
   localparam int DRIVE_UNITY = 65536;    // 1.0 in Q1.16
   localparam int GAIN_CEILING = 58982;   // 0.9 in Q0.16
   localparam int THRESH_MAX = (1 << THRESH_W) - 1;

   typedef struct {
      logic [SAMPLE_BITS-1:0] left;
      logic [SAMPLE_BITS-1:0] right;
   } stereo_frame_type;

   // DUT-facing signals; the bench-driven ones are known from time zero
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [47:0] req_tdata = '0;   // [23:0] left_in, [47:24] right_in
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // [23:0] left_out, [47:24] right_out
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // register shadow copy, updated on each csr transfer
   logic [DRIVE_W-1:0]  cfg_drive_a     = DRIVE_RESET;
   logic [DRIVE_W-1:0]  cfg_drive_b     = DRIVE_RESET;
   logic [THRESH_W-1:0] cfg_clip        = THRESH_RESET;
   logic [GAIN_W-1:0]   cfg_gain_target = GAIN_RESET;
   logic [BLEN_W-1:0]   cfg_frames      = BLEN_RESET;

   // gain ramp state of the predictor
   logic [GAIN_W-1:0] gain_held = GAIN_RESET;
   logic [RAMP_W-1:0] gain_acc  = '0;
   logic [RAMP_W-1:0] gain_inc  = '0;
   logic [POS_W-1:0]  frame_idx = '0;
   bit                in_ramp   = 1'b0;

   logic [47:0]      frame_queue[$];      // frames waiting for the driver
   stereo_frame_type expected_frames[$];  // predicted outputs, oldest first
   int               mismatch_count = 0;

   int send_gap = 0;
   int rsp_stall = 0;
   bit send_steady = 1'b0;
   bit rsp_steady = 1'b0;
   int idle_cycles = 0;

   cubic_hardclip_waveshaper_gain_ramp dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // One soft-clip stage: x - d*x^3/3, every product rounded on the magnitude.
   function automatic longint cubic_stage(longint x, logic [DRIVE_W-1:0] d);
      longint unsigned half;
      longint unsigned m;
      longint unsigned sq;
      longint unsigned cu;
      longint unsigned t;
      longint unsigned third;
      half = longint'(1) << (FRAC_BITS - 1);
      m = (x < 0) ? -x : x;
      sq = (m * m + half) >> FRAC_BITS;
      cu = (sq * m + half) >> FRAC_BITS;
      t = (cu * d + 32768) >> 16;
      third = (t + 1) / 3;
      return (x < 0) ? x + longint'(third) : x - longint'(third);
   endfunction

   // Full per-channel path: two cubic stages, hard-clip blend, gain, saturate.
   function automatic logic [SAMPLE_BITS-1:0] shape_sample(logic [SAMPLE_BITS-1:0] raw,
                                                         logic [GAIN_W-1:0] g);
      longint x;
      longint y;
      longint s;
      longint p;
      longint th;
      longint unsigned pm;
      x = $signed(raw);
      th = longint'(cfg_clip);
      y = cubic_stage(x, cfg_drive_a);
      // stage one can exceed full scale only with drive above 1.0
      if (y > SAMPLE_UNITY) y = SAMPLE_UNITY;
      if (y < -SAMPLE_UNITY) y = -SAMPLE_UNITY;
      y = cubic_stage(y, cfg_drive_b);
      if (x >= th) s = y + th;
      else if (x <= -th) s = y - th;
      else s = y + x;
      p = s * longint'(g);
      pm = (p < 0) ? -p : p;
      pm = (pm + 32768) >> 16;
      p = (p < 0) ? -longint'(pm) : longint'(pm);
      if (p > SAMPLE_UNITY - 1) p = SAMPLE_UNITY - 1;
      if (p < -SAMPLE_UNITY) p = -SAMPLE_UNITY;
      return p[SAMPLE_BITS-1:0];
   endfunction

   // Expected output of one accepted frame; advances the gain ramp state.
   function automatic stereo_frame_type shape_frame(logic [47:0] word);
      int frames;
      longint span;
      logic [GAIN_W-1:0] g;
      stereo_frame_type f;
      frames = int'(cfg_frames);
      if (frames < 1) frames = 1;
      if (frames > MAX_BLOCK) frames = MAX_BLOCK;
      // target gain is only sampled at a block start
      if (frame_idx == '0) begin
         if (cfg_gain_target != gain_held) begin
            span = (longint'(cfg_gain_target) - longint'(gain_held)) * 65536;
            in_ramp = 1'b1;
            gain_acc = {gain_held, 16'h0000};
            gain_inc = RAMP_W'(span / frames);   // truncates toward zero
            gain_held = cfg_gain_target;
         end else begin
            in_ramp = 1'b0;
         end
      end
      g = in_ramp ? gain_acc[RAMP_W-1:RAMP_W-GAIN_W] : gain_held;
      f.left = shape_sample(word[23:0], g);
      f.right = shape_sample(word[47:24], g);
      if (in_ramp) gain_acc = gain_acc + gain_inc;
      // a shrunken block length ends the block at the next frame
      frame_idx = (int'(frame_idx) + 1 >= frames) ? '0 : frame_idx + 1'b1;
      return f;
   endfunction

   // Mostly back-to-back, some short gaps, a few long ones.
   function automatic int pick_gap(bit steady);
      int unsigned roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 14);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] rand_sample();
      logic [SAMPLE_BITS-1:0] v;
      int unsigned pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0: v = S_MAX;
         1: v = S_MIN;
         2: v = SAMPLE_BITS'($urandom_range(0, 255));
         3: v = {1'b0, cfg_clip} + SAMPLE_BITS'($urandom_range(0, 2));
         default: v = SAMPLE_BITS'($urandom());
      endcase
      if ((pick == 2 || pick == 3) && $urandom_range(0, 1) == 1) v = -v;
      return v;
   endfunction

   // csr transfer; shadow registers follow the masking of the block
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_DRIVE_FIRST:    cfg_drive_a = val[DRIVE_W-1:0];
         CSR_DRIVE_SECOND:   cfg_drive_b = val[DRIVE_W-1:0];
         CSR_CLIP_THRESHOLD: cfg_clip = val[THRESH_W-1:0];
         CSR_OUTPUT_GAIN:    cfg_gain_target = val[GAIN_W-1:0];
         CSR_BLOCK_LENGTH:   cfg_frames = val[BLEN_W-1:0];
         default: ;          // unknown index: dropped
      endcase
      csr_valid <= 1'b0;
   endtask

   // appends one frame at the tail of the driver queue
   task automatic enqueue_frame(input logic [47:0] word);
      frame_queue = {frame_queue, word};
   endtask

   task automatic queue_frames(input int count);
      @(negedge clock);
      repeat (count) enqueue_frame({rand_sample(), rand_sample()});
   endtask

   // Sender holds off until every frame is out and answered, then settles.
   task automatic drain();
      @(negedge clock);
      while (frame_queue.size() != 0 || req_tvalid || expected_frames.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Driver: each req transfer is predicted at the edge where it happens.
   always @(posedge clock) begin : drive_req
      bit next_valid;
      next_valid = req_tvalid;
      if (reset) begin
         next_valid = 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_frames = {expected_frames, shape_frame(req_tdata)};
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (frame_queue.size() > 0) begin
               req_tdata <= frame_queue.pop_front();
               next_valid = 1'b1;
               if ($urandom_range(0, 49) == 0) send_steady = !send_steady;
               send_gap = pick_gap(send_steady);
            end
         end
      end
      req_tvalid <= next_valid;
   end

   // Monitor: compares each rsp transfer with the oldest prediction and
   // drops rsp_tready for a random stall after it.
   always @(posedge clock) begin : watch_rsp
      stereo_frame_type want;
      bit next_ready;
      next_ready = rsp_tready;
      if (reset) begin
         next_ready = 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_frames.size() == 0) begin
               $display("%0t: rsp transfer with nothing expected, actual %h",
                        $time, rsp_tdata);
               mismatch_count++;
            end else begin
               want = expected_frames.pop_front();
               if (rsp_tdata[23:0] !== want.left) begin
                  $display("%0t: left_out expected %h actual %h",
                           $time, want.left, rsp_tdata[23:0]);
                  mismatch_count++;
               end
               if (rsp_tdata[47:24] !== want.right) begin
                  $display("%0t: right_out expected %h actual %h",
                           $time, want.right, rsp_tdata[47:24]);
                  mismatch_count++;
               end
            end
            if ($urandom_range(0, 49) == 0) rsp_steady = !rsp_steady;
            rsp_stall = pick_gap(rsp_steady);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            next_ready = 1'b0;
         end else begin
            next_ready = 1'b1;
         end
      end
      rsp_tready <= next_ready;
   end

   // Watchdog: any transfer on any channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int random_left;
      int count;
      int width;
      int unsigned roll;
      logic [CSR_DATA_W-1:0] val;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: gain target equals held gain, so no ramp.
      // Sample extremes, +/-1 LSB, and values around the clip level.
      @(negedge clock);
      enqueue_frame({24'h000000, 24'h000000});
      enqueue_frame({S_MAX, S_MIN});
      enqueue_frame({S_MIN, S_MAX});
      enqueue_frame({S_NEG_ONE, S_ONE});
      enqueue_frame({S_ONE, S_NEG_ONE});
      enqueue_frame({S_NEG_HALF, S_HALF});
      enqueue_frame({S_HALF - S_ONE, S_NEG_HALF - S_ONE});
      enqueue_frame({S_HALF + S_ONE, S_NEG_HALF + S_ONE});
      enqueue_frame({S_MAX, S_MAX});
      enqueue_frame({S_MIN, S_MIN});
      drain();

      // Unity first drive, second drive above 1.0 through masking, zero clip
      // level, gain ramp up over a 4-frame block; unknown indexes are dropped.
      write_reg(CSR_DRIVE_FIRST, CSR_DATA_W'(DRIVE_UNITY));
      write_reg(CSR_DRIVE_SECOND, '1);
      write_reg(CSR_CLIP_THRESHOLD, '0);
      write_reg(CSR_OUTPUT_GAIN, CSR_DATA_W'(GAIN_CEILING));
      write_reg(CSR_BLOCK_LENGTH, CSR_DATA_W'(4));
      write_reg(CSR_BLOCK_LENGTH + 1'b1, '1);
      write_reg('1, '0);
      @(negedge clock);
      enqueue_frame({S_MAX, S_MIN});
      enqueue_frame({S_MIN, S_MAX});
      enqueue_frame({S_MAX, S_MAX});
      enqueue_frame({S_HALF, S_NEG_HALF});
      enqueue_frame({S_MIN, S_MIN});
      enqueue_frame({24'h000000, S_ONE});
      enqueue_frame({S_NEG_ONE, 24'h000000});
      enqueue_frame({24'h123456, 24'hEDCBA9});
      drain();

      // Full-width writes: first drive and gain masked to all ones, second drive
      // zero, clip level at its maximum, block length zero so every frame opens a block.
      write_reg(CSR_DRIVE_FIRST, '1);
      write_reg(CSR_DRIVE_SECOND, '0);
      write_reg(CSR_CLIP_THRESHOLD, CSR_DATA_W'(THRESH_MAX));
      write_reg(CSR_OUTPUT_GAIN, '1);
      write_reg(CSR_BLOCK_LENGTH, '0);
      @(negedge clock);
      enqueue_frame({S_MAX, S_MIN});
      enqueue_frame({S_MIN, S_MAX});
      enqueue_frame({S_MAX, S_MAX});
      enqueue_frame({S_HALF, S_NEG_HALF});
      enqueue_frame({S_MIN, S_MIN});
      drain();

      random_left = RANDOM_FRAMES;

      // Oversized block length clamps to the max; ramp down to zero gain.
      // Then change the gain mid-block and shrink the block below the
      // current position: the block ends on the next frame.
      write_reg(CSR_OUTPUT_GAIN, '0);
      write_reg(CSR_BLOCK_LENGTH, '1);
      queue_frames(150);
      drain();
      write_reg(CSR_OUTPUT_GAIN, CSR_DATA_W'(20000));
      write_reg(CSR_BLOCK_LENGTH, CSR_DATA_W'(5));
      queue_frames(40);
      drain();
      random_left -= 190;

      // Random settings per run of frames, extremes weighted in.
      while (random_left > 0) begin
         for (int r = 0; r <= int'(CSR_BLOCK_LENGTH); r++) begin
            if ($urandom_range(0, 9) < 6) begin
               roll = $urandom_range(0, 9);
               case (CSR_INDEX_W'(r))
                  CSR_DRIVE_FIRST, CSR_DRIVE_SECOND: begin
                     width = DRIVE_W;
                     case (roll)
                        0: val = '0;
                        1: val = CSR_DATA_W'(DRIVE_UNITY);
                        2: val = CSR_DATA_W'({DRIVE_W{1'b1}});
                        3: val = CSR_DATA_W'($urandom_range(0, (1 << DRIVE_W) - 1));
                        default: val = CSR_DATA_W'($urandom_range(0, DRIVE_UNITY));
                     endcase
                  end
                  CSR_CLIP_THRESHOLD: begin
                     width = THRESH_W;
                     case (roll)
                        0: val = '0;
                        1: val = CSR_DATA_W'(THRESH_MAX);
                        default: val = CSR_DATA_W'($urandom_range(0, THRESH_MAX));
                     endcase
                  end
                  CSR_OUTPUT_GAIN: begin
                     width = GAIN_W;
                     case (roll)
                        0: val = '0;
                        1: val = CSR_DATA_W'(GAIN_CEILING);
                        2: val = CSR_DATA_W'({GAIN_W{1'b1}});
                        3: val = CSR_DATA_W'($urandom_range(0, (1 << GAIN_W) - 1));
                        default: val = CSR_DATA_W'($urandom_range(0, GAIN_CEILING));
                     endcase
                  end
                  default: begin
                     // block length: mostly short so ramps and wraps happen often
                     width = BLEN_W;
                     case (roll)
                        0: val = '0;
                        1: val = CSR_DATA_W'(1);
                        2: val = CSR_DATA_W'(MAX_BLOCK);
                        3: val = CSR_DATA_W'($urandom_range(MAX_BLOCK + 1, (1 << BLEN_W) - 1));
                        4, 5: val = CSR_DATA_W'($urandom_range(2, 16));
                        6, 7: val = CSR_DATA_W'($urandom_range(17, 300));
                        default: val = CSR_DATA_W'($urandom_range(1, 64));
                     endcase
                  end
               endcase
               // junk above the register width must be ignored
               if ($urandom_range(0, 7) == 0 && width < CSR_DATA_W)
                  val = val | (CSR_DATA_W'($urandom()) << width);
               write_reg(CSR_INDEX_W'(r), val);
            end
         end
         if ($urandom_range(0, 3) == 0)
            write_reg(CSR_INDEX_W'($urandom_range(int'(CSR_BLOCK_LENGTH) + 1,
                                                   (1 << CSR_INDEX_W) - 1)),
                      CSR_DATA_W'($urandom()));
         count = $urandom_range(20, 160);
         if (count > random_left) count = random_left;
         queue_frames(count);
         drain();
         random_left -= count;
      end

      if (mismatch_count == 0 && expected_frames.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
